### design/gdbpd_pkg.sv
// ----------------------------------------------------------------------------
// gdbpd_pkg
// Shared constants, types and helpers for the debugger packet deframer.
// ----------------------------------------------------------------------------
package gdbpd_pkg;

	// Payload buffer size minus one; the effective limit never exceeds it
	localparam int MAX_PAYLOAD = 4095;

	localparam int CNT_W = 12;
	localparam int CFG_IDX_W = 2;

	// Cap applied to the programmed payload limit
	localparam logic [CNT_W-1:0] LIMIT_CAP =
		(MAX_PAYLOAD > 4095) ? {CNT_W{1'b1}} : CNT_W'(MAX_PAYLOAD);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NO_ACK = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(1);
	localparam logic [CNT_W-1:0]     LIMIT_RESET = {CNT_W{1'b1}};

	// Framing characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BREAK  = 8'h03;

	// Event codes
	localparam logic [2:0] EV_BYTE     = 3'd0;
	localparam logic [2:0] EV_GOOD     = 3'd1;
	localparam logic [2:0] EV_BAD      = 3'd2;
	localparam logic [2:0] EV_BREAK    = 3'd3;
	localparam logic [2:0] EV_OVERFLOW = 3'd4;

	// Reply codes
	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_ACK  = 2'd1;
	localparam logic [1:0] REPLY_NAK  = 2'd2;

	typedef struct packed {
		logic             no_ack;
		logic [CNT_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic             hit;
		logic [2:0]       ev;
		logic [7:0]       data;
		logic [CNT_W-1:0] idx;
		logic [CNT_W-1:0] len;
		logic [1:0]       reply;
	} res_t;

	typedef struct packed {
		logic idle;
	} stat_t;

	// Hex digit decode: {valid, nibble}; nibble is zero for a non-hex byte
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end
		return r;
	endfunction

endpackage

### design/gdbpd_rx_if.sv
// ----------------------------------------------------------------------------
// gdbpd_rx_if
// Received character channel: one byte per transaction.
// ----------------------------------------------------------------------------
interface gdbpd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink (input valid, input rx_char, output ready);
endinterface

### design/gdbpd_res_if.sv
// ----------------------------------------------------------------------------
// gdbpd_res_if
// Result channel: one deframer event per transaction.
// ----------------------------------------------------------------------------
interface gdbpd_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  payload_byte;
	logic [11:0] byte_index;
	logic [11:0] packet_length;
	logic [1:0]  reply;

	modport source (output valid, output event_res, output payload_byte,
		output byte_index, output packet_length, output reply, input ready);
	modport sink (input valid, input event_res, input payload_byte,
		input byte_index, input packet_length, input reply, output ready);
endinterface

### design/gdbpd_cfg_if.sv
// ----------------------------------------------------------------------------
// gdbpd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gdbpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/gdb_packet_deframer_checker.sv
// ----------------------------------------------------------------------------
// gdb_packet_deframer_checker
// Debugger packet deframer: recognizes $payload#hh framing, reports payload
// bytes with index, checksum verdict with ack/nak reply, breaks and overflow.
//
//   Channel  Dir  Transaction
//   rx       in   one received character (rx_char)
//   res      out  one event: event_res, payload_byte, byte_index,
//                 packet_length, reply
//   cfg      in   register write: index 0 no_ack_mode, 1 payload_limit
//
// One character per cycle; an event appears on res the cycle after its
// character is taken. The parser update is a single step from parser state
// and character into the result register. rx stalls only while a result is
// held and res is not ready. cfg is always ready. Reset leaves the parser
// idle, no_ack_mode 0 and payload_limit 4095.
// ----------------------------------------------------------------------------
module gdb_packet_deframer_checker (
	input logic          clk,
	input logic          arst_n,
	gdbpd_rx_if.sink     rx,
	gdbpd_res_if.source  res,
	gdbpd_cfg_if.sink    cfg
);
	import gdbpd_pkg::*;

	cfg_t       cfg_q;
	res_t       pres;
	stat_t      pstat;
	logic       take;
	logic       out_valid_q;
	logic [2:0] ev_q;
	logic [7:0] data_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] len_q;
	logic [1:0] reply_q;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.no_ack <= 1'b0;
			cfg_q.limit <= LIMIT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_NO_ACK) begin
				cfg_q.no_ack <= cfg.data[0];
			end else if (cfg.index == CFG_LIMIT) begin
				cfg_q.limit <= cfg.data;
			end
		end
	end

	// Input handshake: accept whenever the result register is free or draining
	assign rx.ready = !out_valid_q || res.ready;
	assign take = rx.valid && rx.ready;

	gdbpd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_char (rx.rx_char),
		.cfg     (cfg_q),
		.res     (pres),
		.stat    (pstat)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= pres.hit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_q <= pres.ev;
			data_q <= pres.data;
			idx_q <= pres.idx;
			len_q <= pres.len;
			reply_q <= pres.reply;
		end
	end

	assign res.valid = out_valid_q;
	assign res.event_res = ev_q;
	assign res.payload_byte = data_q;
	assign res.byte_index = idx_q;
	assign res.packet_length = len_q;
	assign res.reply = reply_q;

	// A reply character goes out only with a checksum verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.reply != REPLY_NONE |->
			res.event_res == EV_GOOD || res.event_res == EV_BAD)
		else $error("reply without packet verdict");

	// A dollar sign taken while idle opens a packet and reports nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		take && pstat.idle && rx.rx_char == CH_DOLLAR |=> !pstat.idle && !res.valid)
		else $error("packet start not recognized");

	// A break is only reported for a character taken while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		take && !pstat.idle |=> !(res.valid && res.event_res == EV_BREAK))
		else $error("break reported inside packet");

	// Payload byte events carry no length and no reply
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.event_res == EV_BYTE |->
			res.packet_length == '0 && res.reply == REPLY_NONE)
		else $error("payload byte event with verdict fields");

endmodule

### design/gdbpd_parser.sv
// ----------------------------------------------------------------------------
// gdbpd_parser
// Packet parser state and per-character event decode. Event is combinational
// from the current state and the offered byte; state advances on take.
// ----------------------------------------------------------------------------
module gdbpd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_char,
	input  gdbpd_pkg::cfg_t   cfg,
	output gdbpd_pkg::res_t   res,
	output gdbpd_pkg::stat_t  stat
);
	import gdbpd_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_DATA,
		MODE_CSUM_HI,
		MODE_CSUM_LO
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [7:0]       sum_q, sum_d;
	logic [3:0]       hi_q, hi_d;
	logic             hi_ok_q, hi_ok_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] limit;
	logic [4:0]       hex;

	assign limit = (cfg.limit > LIMIT_CAP) ? LIMIT_CAP : cfg.limit;
	assign hex = hex_decode(rx_char);
	assign stat.idle = (mode_q == MODE_IDLE);

	// Next state and event for the offered character
	always_comb begin
		mode_d = mode_q;
		sum_d = sum_q;
		hi_d = hi_q;
		hi_ok_d = hi_ok_q;
		count_d = count_q;
		res = '0;
		case (mode_q)
			MODE_IDLE: begin
				if (rx_char == CH_DOLLAR) begin
					mode_d = MODE_DATA;
					sum_d = '0;
					hi_d = '0;
					hi_ok_d = 1'b0;
					count_d = '0;
				end else if (rx_char == CH_BREAK) begin
					res.hit = 1'b1;
					res.ev = EV_BREAK;
				end
			end
			MODE_DATA: begin
				if (rx_char == CH_HASH) begin
					mode_d = MODE_CSUM_HI;
				end else if (count_q >= limit) begin
					// packet too long: drop it
					mode_d = MODE_IDLE;
					sum_d = '0;
					hi_d = '0;
					hi_ok_d = 1'b0;
					count_d = '0;
					res.hit = 1'b1;
					res.ev = EV_OVERFLOW;
				end else begin
					res.hit = 1'b1;
					res.ev = EV_BYTE;
					res.data = rx_char;
					res.idx = count_q;
					sum_d = sum_q + rx_char;
					count_d = count_q + 1'b1;
				end
			end
			MODE_CSUM_HI: begin
				hi_d = hex[3:0];
				hi_ok_d = hex[4];
				mode_d = MODE_CSUM_LO;
			end
			MODE_CSUM_LO: begin
				mode_d = MODE_IDLE;
				sum_d = '0;
				hi_d = '0;
				hi_ok_d = 1'b0;
				count_d = '0;
				res.hit = 1'b1;
				res.len = count_q;
				if (cfg.no_ack) begin
					res.ev = EV_GOOD;
					res.reply = REPLY_NONE;
				end else if (hi_ok_q && hex[4] && sum_q == {hi_q, hex[3:0]}) begin
					res.ev = EV_GOOD;
					res.reply = REPLY_ACK;
				end else begin
					res.ev = EV_BAD;
					res.reply = REPLY_NAK;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			sum_q <= '0;
			hi_q <= '0;
			hi_ok_q <= 1'b0;
			count_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			sum_q <= sum_d;
			hi_q <= hi_d;
			hi_ok_q <= hi_ok_d;
			count_q <= count_d;
		end
	end

endmodule

### tb/sv/gdb_packet_deframer_checker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdb_packet_deframer_checker_test
// Self-checking bench for the debugger packet deframer. A directed table walks
// framing, break, payload data, checksum verdicts, overflow and no-ack mode.
// Random packets and line noise follow under several register settings. Every
// event is compared field by field against an in-bench parser model or a
// typed row event, with random idling on the character and event channels.
// ----------------------------------------------------------------------------
module gdb_packet_deframer_checker_test;
	import gdbpd_pkg::*;

	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_CYCLES     = 200;
	localparam int SETTLE_CYCLES   = 4;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 62;

	typedef enum logic [1:0] {PM_IDLE, PM_DATA, PM_CSUM_HI, PM_CSUM_LO} parse_mode_e;

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  data;
		logic [11:0] idx;
		logic [11:0] len;
		logic [1:0]  reply;
	} deframe_ev_t;

	typedef enum logic [1:0] {ROW_CHAR, ROW_NO_ACK, ROW_LIMIT} row_kind_e;
	// How a directed row is checked: by the model, as silent, or by a typed event
	typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_EVENT} row_check_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [11:0] val;
		row_check_e  chk;
		deframe_ev_t want;
	} dir_row_t;

	localparam deframe_ev_t NO_EV    = '0;
	localparam deframe_ev_t BREAK_EV = '{EV_BREAK, 8'h00, 12'd0, 12'd0, REPLY_NONE};
	localparam deframe_ev_t OVF_EV   = '{EV_OVERFLOW, 8'h00, 12'd0, 12'd0, REPLY_NONE};

	// Directed stimulus
	dir_row_t dir_table [33] = '{
		'{ROW_CHAR,   12'h041, CHK_QUIET, NO_EV},   // stray byte while idle
		'{ROW_CHAR,   12'h003, CHK_EVENT, BREAK_EV},
		'{ROW_CHAR,   12'h024, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h000, CHK_EVENT, '{EV_BYTE, 8'h00, 12'd0, 12'd0, REPLY_NONE}},
		'{ROW_CHAR,   12'h0FF, CHK_EVENT, '{EV_BYTE, 8'hFF, 12'd1, 12'd0, REPLY_NONE}},
		'{ROW_CHAR,   12'h024, CHK_EVENT, '{EV_BYTE, 8'h24, 12'd2, 12'd0, REPLY_NONE}},
		'{ROW_CHAR,   12'h003, CHK_EVENT, '{EV_BYTE, 8'h03, 12'd3, 12'd0, REPLY_NONE}},
		'{ROW_CHAR,   12'h023, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h032, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h036, CHK_MODEL, NO_EV},   // checksum 0x26
		'{ROW_CHAR,   12'h024, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h0AF, CHK_MODEL, NO_EV},
		'{ROW_CHAR,   12'h023, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h061, CHK_QUIET, NO_EV},   // mixed case digits
		'{ROW_CHAR,   12'h046, CHK_MODEL, NO_EV},
		'{ROW_CHAR,   12'h024, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h023, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h067, CHK_QUIET, NO_EV},   // non-hex high digit
		'{ROW_CHAR,   12'h030, CHK_EVENT, '{EV_BAD, 8'h00, 12'd0, 12'd0, REPLY_NAK}},
		'{ROW_LIMIT,  12'd1,   CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h024, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h061, CHK_EVENT, '{EV_BYTE, 8'h61, 12'd0, 12'd0, REPLY_NONE}},
		'{ROW_CHAR,   12'h062, CHK_EVENT, OVF_EV},
		'{ROW_LIMIT,  12'd0,   CHK_QUIET, NO_EV},   // every payload byte overflows
		'{ROW_CHAR,   12'h024, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h071, CHK_EVENT, OVF_EV},
		'{ROW_NO_ACK, 12'd1,   CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h024, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h023, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h07A, CHK_QUIET, NO_EV},
		'{ROW_CHAR,   12'h07A, CHK_EVENT, '{EV_GOOD, 8'h00, 12'd0, 12'd0, REPLY_NONE}},
		'{ROW_NO_ACK, 12'd0,   CHK_QUIET, NO_EV},
		'{ROW_LIMIT,  12'hFFF, CHK_QUIET, NO_EV}
	};

	logic clk;
	logic arst_n;

	gdbpd_rx_if  rx_link();
	gdbpd_res_if ev_link();
	gdbpd_cfg_if reg_link();

	gdb_packet_deframer_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_link),
		.res(ev_link),
		.cfg(reg_link)
	);

	// Parser model state and register copies
	parse_mode_e pmode = PM_IDLE;
	logic [7:0]  run_sum = 8'h00;
	logic [3:0]  hi_nib = 4'h0;
	logic        hi_ok = 1'b0;
	logic [11:0] pcount = 12'd0;
	logic        cfg_no_ack = 1'b0;
	logic [11:0] cfg_limit = LIMIT_RESET;

	deframe_ev_t pending_events[$];
	int n_chars = 0;
	int n_fail = 0;
	int ev_seen [5] = '{0, 0, 0, 0, 0};
	int quiet_cycles = 0;

	bit hold_req = 1'b0;
	bit tx_gaps_on = 1'b1;
	bit rx_stalls_on = 1'b1;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
		if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
		return 5'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return (upper ? 8'h41 : 8'h61) + 8'(n - 4'd10);
	endfunction

	function automatic void clear_packet();
		pmode = PM_IDLE;
		run_sum = 8'h00;
		hi_nib = 4'h0;
		hi_ok = 1'b0;
		pcount = 12'd0;
	endfunction

	// Advance the parser model by one character; returns 1 when an event results
	function automatic bit step_parser(input logic [7:0] c, output deframe_ev_t ev);
		logic [11:0] lim;
		logic [4:0]  lo;
		ev = '0;
		lim = (cfg_limit < LIMIT_CAP) ? cfg_limit : LIMIT_CAP;
		case (pmode)
			PM_IDLE: begin
				if (c == CH_DOLLAR) begin
					clear_packet();
					pmode = PM_DATA;
				end else if (c == CH_BREAK) begin
					ev.ev = EV_BREAK;
					return 1'b1;
				end
				return 1'b0;
			end
			PM_DATA: begin
				if (c == CH_HASH) begin
					pmode = PM_CSUM_HI;
					return 1'b0;
				end
				if (pcount >= lim) begin
					clear_packet();
					ev.ev = EV_OVERFLOW;
					return 1'b1;
				end
				ev.ev = EV_BYTE;
				ev.data = c;
				ev.idx = pcount;
				run_sum = run_sum + c;
				pcount = pcount + 12'd1;
				return 1'b1;
			end
			PM_CSUM_HI: begin
				{hi_ok, hi_nib} = nibble_of(c);
				pmode = PM_CSUM_LO;
				return 1'b0;
			end
			default: begin
				lo = nibble_of(c);
				ev.len = pcount;
				if (cfg_no_ack) begin
					ev.ev = EV_GOOD;
					ev.reply = REPLY_NONE;
				end else if (hi_ok && lo[4] && run_sum == {hi_nib, lo[3:0]}) begin
					ev.ev = EV_GOOD;
					ev.reply = REPLY_ACK;
				end else begin
					ev.ev = EV_BAD;
					ev.reply = REPLY_NAK;
				end
				clear_packet();
				return 1'b1;
			end
		endcase
	endfunction

	// Present one character and wait for its transaction
	task automatic offer_char(input logic [7:0] c);
		@(negedge clk);
		rx_link.valid <= 1'b1;
		rx_link.rx_char <= c;
		@(posedge clk);
		while (!rx_link.ready) @(posedge clk);
	endtask

	task automatic tx_pause();
		int n;
		if (tx_gaps_on && $urandom_range(0, 2) == 0) begin
			n = pick_gap();
			@(negedge clk);
			rx_link.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic feed(input logic [7:0] c);
		deframe_ev_t ev;
		offer_char(c);
		if (step_parser(c, ev)) pending_events.push_back(ev);
		n_chars++;
		tx_pause();
	endtask

	// Stop sending until every expected event has arrived, then let the block settle
	task automatic drain();
		@(negedge clk);
		rx_link.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
		// Close any open packet so the parser is idle
		while (pmode != PM_IDLE) feed((pmode == PM_DATA) ? CH_HASH : hex_char(4'h0, 1'b0));
		drain();
		@(negedge clk);
		reg_link.valid <= 1'b1;
		reg_link.index <= idx;
		reg_link.data <= data;
		@(posedge clk);
		while (!reg_link.ready) @(posedge clk);
		if (idx == CFG_NO_ACK) cfg_no_ack = data[0];
		else if (idx == CFG_LIMIT) cfg_limit = data;
		@(negedge clk);
		reg_link.valid <= 1'b0;
	endtask

	function automatic logic [7:0] payload_char();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: b = CH_DOLLAR;
			1: b = CH_BREAK;
			default: begin
				b = 8'($urandom_range(0, 254));
				if (b >= CH_HASH) b = b + 8'd1;
			end
		endcase
		return b;
	endfunction

	function automatic int pick_len();
		int lim;
		lim = (cfg_limit < LIMIT_CAP) ? cfg_limit : LIMIT_CAP;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: return $urandom_range(0, 8);
			7, 8: return $urandom_range(9, 40);
			default: return (lim <= 64) ? lim + $urandom_range(0, 2) : $urandom_range(41, 80);
		endcase
	endfunction

	// One framed packet; a bad one carries a wrong or malformed checksum
	task automatic send_packet(input int len, input bit sum_ok);
		logic [7:0] s;
		logic [7:0] b;
		s = 8'h00;
		feed(CH_DOLLAR);
		for (int i = 0; i < len; i++) begin
			b = payload_char();
			feed(b);
			s = s + b;
		end
		feed(CH_HASH);
		if (sum_ok) begin
			feed(hex_char(s[7:4], $urandom_range(0, 1)));
			feed(hex_char(s[3:0], $urandom_range(0, 1)));
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					s = s ^ 8'($urandom_range(1, 255));
					feed(hex_char(s[7:4], $urandom_range(0, 1)));
					feed(hex_char(s[3:0], $urandom_range(0, 1)));
				end
				1: begin
					feed(8'($urandom_range(0, 255)));
					feed(hex_char(s[3:0], 1'b0));
				end
				default: begin
					feed(hex_char(s[7:4], 1'b1));
					feed(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	// Event receiver: random stalls plus one long requested hold
	initial begin : event_sink
		int stall_left;
		stall_left = 0;
		ev_link.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				ev_link.ready <= 1'b0;
				stall_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				ev_link.ready <= 1'b0;
				stall_left = HOLD_CYCLES - 1;
			end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
				ev_link.ready <= 1'b0;
				stall_left = pick_gap() - 1;
			end else begin
				ev_link.ready <= 1'b1;
			end
		end
	end

	// Compare each event transaction with the oldest expectation
	always @(posedge clk) begin
		deframe_ev_t want;
		if (arst_n && ev_link.valid && ev_link.ready) begin
			if (ev_link.event_res <= EV_OVERFLOW) ev_seen[ev_link.event_res]++;
			if (pending_events.size() == 0) begin
				$error("unexpected event: event_res %0d payload_byte %0h",
					ev_link.event_res, ev_link.payload_byte);
				n_fail++;
			end else begin
				want = pending_events.pop_front();
				if (ev_link.event_res !== want.ev) begin
					$error("event_res: expected %0d, got %0d", want.ev, ev_link.event_res);
					n_fail++;
				end
				if (ev_link.payload_byte !== want.data) begin
					$error("payload_byte: expected %0h, got %0h", want.data, ev_link.payload_byte);
					n_fail++;
				end
				if (ev_link.byte_index !== want.idx) begin
					$error("byte_index: expected %0d, got %0d", want.idx, ev_link.byte_index);
					n_fail++;
				end
				if (ev_link.packet_length !== want.len) begin
					$error("packet_length: expected %0d, got %0d", want.len,
						ev_link.packet_length);
					n_fail++;
				end
				if (ev_link.reply !== want.reply) begin
					$error("reply: expected %0d, got %0d", want.reply, ev_link.reply);
					n_fail++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_link.valid && rx_link.ready) || (ev_link.valid && ev_link.ready) ||
					(reg_link.valid && reg_link.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		dir_row_t    row;
		deframe_ev_t ev;
		bit          got;
		int          base;
		bit          mid_done;
		logic        nack;
		logic [11:0] lim;

		arst_n = 1'b0;
		rx_link.valid = 1'b0;
		rx_link.rx_char = 8'h00;
		reg_link.valid = 1'b0;
		reg_link.index = CFG_NO_ACK;
		reg_link.data = 12'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		foreach (dir_table[i]) begin
			row = dir_table[i];
			case (row.kind)
				ROW_NO_ACK: write_reg(CFG_NO_ACK, row.val);
				ROW_LIMIT: write_reg(CFG_LIMIT, row.val);
				default: begin
					offer_char(row.val[7:0]);
					got = step_parser(row.val[7:0], ev);
					if (row.chk == CHK_EVENT) pending_events.push_back(row.want);
					else if (row.chk == CHK_MODEL && got) pending_events.push_back(ev);
					n_chars++;
					tx_pause();
				end
			endcase
		end

		// Random phases under different register settings
		for (int p = 0; p < PHASES; p++) begin
			nack = 1'b0;
			lim = LIMIT_RESET;
			case (p)
				1: lim = 12'($urandom_range(2, 16));
				2: begin
					nack = 1'b1;
					lim = 12'($urandom_range(8, 64));
				end
				3: lim = 12'd1;
				4: nack = 1'b1;
				default: ;
			endcase
			write_reg(CFG_NO_ACK, {11'd0, nack});
			write_reg(CFG_LIMIT, lim);

			if (p == 0) begin
				// Long output hold while characters keep coming
				tx_gaps_on = 1'b0;
				hold_req = 1'b1;
				send_packet(40, 1'b1);
			end

			base = n_chars;
			mid_done = 1'b0;
			while (n_chars - base < ITEMS_PER_PHASE) begin
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_stalls_on = ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 19))
					0, 1: repeat ($urandom_range(1, 4))
						feed(($urandom_range(0, 3) == 0) ? CH_BREAK : 8'($urandom_range(0, 255)));
					2, 3, 4: send_packet(pick_len(), 1'b0);
					default: send_packet(pick_len(), 1'b1);
				endcase
				if (!mid_done && n_chars - base >= ITEMS_PER_PHASE / 2) begin
					drain();
					mid_done = 1'b1;
				end
			end
		end

		drain();
		$display("Sent %0d characters; checked %0d payload bytes, %0d good and %0d bad packets,",
			n_chars, ev_seen[EV_BYTE], ev_seen[EV_GOOD], ev_seen[EV_BAD]);
		$display("%0d breaks and %0d overflows, with no-ack on and off and limits 0 to 4095.",
			ev_seen[EV_BREAK], ev_seen[EV_OVERFLOW]);
		if (n_fail == 0 && pending_events.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
